[src/sat_pkg.sv]
// Shared types and constants for the section address translator.
// No dependencies; used by sat_sect_mem, sat_engine and the top level.
`default_nettype none

package sat_pkg;

    // Field widths fixed by the interface
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned CFG_IDX_W = 1;

    // Reset value of the image base register
    localparam logic [ADDR_W-1:0] IMAGE_BASE_RST = 32'h0040_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE    = 1'd1;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD       = 2'd0,
        CMD_QUERY_REL  = 2'd1,
        CMD_QUERY_FILE = 2'd2,
        CMD_QUERY_VIRT = 2'd3
    } t_cmd;

    // Engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_XLATE,
        ST_DONE
    } t_state;

    // One table entry; range ends are precomputed at load time (mod 2^32)
    typedef struct packed {
        logic [ADDR_W-1:0] virt_start;
        logic [ADDR_W-1:0] virt_end;
        logic [ADDR_W-1:0] raw_start;
        logic [ADDR_W-1:0] raw_end;
    } t_sect_entry;

    // Write side of the section table
    typedef struct packed {
        logic        we;
        t_sect_entry data;
    } t_mem_wr;

endpackage

`default_nettype wire

[src/sat_sect_mem.sv]
// Section table: single write port, single read port, registered read data.
// Depends on sat_pkg for the entry type.
`default_nettype none

module sat_sect_mem #(
    parameter int unsigned MAX_SECTIONS = 64,
    parameter int unsigned IDX_W        = 6
) (
    input  wire                    i_clk,
    input  wire  sat_pkg::t_mem_wr i_wr,
    input  wire  [IDX_W-1:0]       i_waddr,
    input  wire                    i_re,
    input  wire  [IDX_W-1:0]       i_raddr,
    output sat_pkg::t_sect_entry   o_rdata
);

    sat_pkg::t_sect_entry r_mem [MAX_SECTIONS];
    sat_pkg::t_sect_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/sat_engine.sv]
// Command sequencer: config registers, table loads, in-order scan with
// pipelined table reads, translation and the result register.
// Depends on sat_pkg; drives the ports of sat_sect_mem.
`default_nettype none

module sat_engine #(
    parameter int unsigned MAX_SECTIONS = 64,
    parameter int unsigned IDX_W        = 6,
    parameter int unsigned CNT_W        = 7
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration
    input  wire                                 i_cfg_we,
    input  wire  [sat_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_cfg_wdata,
    // input channel
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [sat_pkg::CMD_W-1:0]           i_command,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_query_address,
    input  wire  [sat_pkg::SLOT_W-1:0]          i_entry_index,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_entry_virt_start,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_entry_virt_size,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_entry_raw_start,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_entry_raw_size,
    // output channel
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [sat_pkg::ADDR_W-1:0]          o_file_offset,
    output logic [sat_pkg::ADDR_W-1:0]          o_relative_address,
    output logic [sat_pkg::ADDR_W-1:0]          o_virtual_address,
    output logic [sat_pkg::SLOT_W-1:0]          o_section_number,
    output logic                                o_hit,
    // section table
    output sat_pkg::t_mem_wr                    o_mem_wr,
    output logic [IDX_W-1:0]                    o_mem_waddr,
    output logic                                o_mem_re,
    output logic [IDX_W-1:0]                    o_mem_raddr,
    input  wire  sat_pkg::t_sect_entry          i_mem_rdata
);

    localparam int unsigned CMPW = 8;

    sat_pkg::t_state              r_state, n_state;

    logic [sat_pkg::COUNT_W-1:0]  r_count;
    logic [sat_pkg::ADDR_W-1:0]   r_base;

    sat_pkg::t_cmd                r_cmd;
    logic [sat_pkg::ADDR_W-1:0]   r_key;
    logic [sat_pkg::ADDR_W-1:0]   r_virt;
    logic [CNT_W-1:0]             r_lim;
    logic [CNT_W-1:0]             r_issue;
    logic                         r_pend;
    logic [IDX_W-1:0]             r_pend_idx;

    logic                         r_hit;
    logic [IDX_W-1:0]             r_slot;
    logic [sat_pkg::ADDR_W-1:0]   r_m_start;
    logic [sat_pkg::ADDR_W-1:0]   r_m_other;
    logic [sat_pkg::ADDR_W-1:0]   r_trans;

    logic                         in_xfer;
    logic                         is_load;
    logic                         slot_ok;
    logic [CNT_W-1:0]             lim;
    logic                         issue_more;
    logic                         file_mode;
    logic [sat_pkg::ADDR_W-1:0]   sel_start;
    logic [sat_pkg::ADDR_W-1:0]   sel_end;
    logic [sat_pkg::ADDR_W-1:0]   oth_start;
    logic                         match;
    logic                         scan_hit;
    logic                         scan_miss;
    logic                         out_free;

    // Handshake
    assign o_in_stall = (r_state != sat_pkg::ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign is_load    = (sat_pkg::t_cmd'(i_command) == sat_pkg::CMD_LOAD);
    assign out_free   = !o_out_valid || !i_out_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_base  <= sat_pkg::IMAGE_BASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sat_pkg::CFG_SECTION_COUNT: r_count <= i_cfg_wdata[sat_pkg::COUNT_W-1:0];
                sat_pkg::CFG_IMAGE_BASE:    r_base  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Scan limit saturates at the table depth
    assign lim = ({1'b0, r_count} > CMPW'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
                                                          : CNT_W'(r_count);

    // Table load: slots beyond the table are dropped
    assign slot_ok     = ({2'b00, i_entry_index} < CMPW'(MAX_SECTIONS));
    assign o_mem_wr.we = in_xfer && is_load && slot_ok;
    assign o_mem_waddr = IDX_W'(i_entry_index);
    assign o_mem_wr.data.virt_start = i_entry_virt_start;
    assign o_mem_wr.data.virt_end   = i_entry_virt_start + i_entry_virt_size;
    assign o_mem_wr.data.raw_start  = i_entry_raw_start;
    assign o_mem_wr.data.raw_end    = i_entry_raw_start + i_entry_raw_size;

    // Table read issue, one entry per cycle
    assign issue_more  = (r_issue < r_lim);
    assign o_mem_re    = (r_state == sat_pkg::ST_SCAN) && issue_more;
    assign o_mem_raddr = r_issue[IDX_W-1:0];

    // Range check on returned entry; a wrapped end never matches
    assign file_mode = (r_cmd == sat_pkg::CMD_QUERY_FILE);
    assign sel_start = file_mode ? i_mem_rdata.raw_start  : i_mem_rdata.virt_start;
    assign sel_end   = file_mode ? i_mem_rdata.raw_end    : i_mem_rdata.virt_end;
    assign oth_start = file_mode ? i_mem_rdata.virt_start : i_mem_rdata.raw_start;
    assign match     = (r_key >= sel_start) && (r_key < sel_end);
    assign scan_hit  = (r_state == sat_pkg::ST_SCAN) && r_pend && match;
    assign scan_miss = (r_state == sat_pkg::ST_SCAN) && !r_pend && !issue_more;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sat_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sat_pkg::ST_IDLE: begin
                if (in_xfer && !is_load) begin
                    n_state = sat_pkg::ST_SCAN;
                end
            end
            sat_pkg::ST_SCAN: begin
                if (scan_hit || scan_miss) begin
                    n_state = sat_pkg::ST_XLATE;
                end
            end
            sat_pkg::ST_XLATE: n_state = sat_pkg::ST_DONE;
            sat_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = sat_pkg::ST_IDLE;
                end
            end
            default: n_state = sat_pkg::ST_IDLE;
        endcase
    end

    // Scan pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= '0;
            r_pend  <= 1'b0;
        end else if (r_state == sat_pkg::ST_IDLE) begin
            r_issue <= '0;
            r_pend  <= 1'b0;
        end else if (r_state == sat_pkg::ST_SCAN) begin
            r_pend <= issue_more && !scan_hit;
            if (issue_more) begin
                r_issue <= r_issue + CNT_W'(1);
            end
        end
    end

    // Query capture: key is the relative address, or the file offset in file mode
    always_ff @(posedge i_clk) begin
        if (in_xfer && !is_load) begin
            r_cmd <= sat_pkg::t_cmd'(i_command);
            r_lim <= lim;
            case (sat_pkg::t_cmd'(i_command))
                sat_pkg::CMD_QUERY_VIRT: begin
                    r_key  <= i_query_address - r_base;
                    r_virt <= i_query_address;
                end
                default: begin
                    r_key  <= i_query_address;
                    r_virt <= i_query_address + r_base;
                end
            endcase
        end
        if (o_mem_re) begin
            r_pend_idx <= r_issue[IDX_W-1:0];
        end
    end

    // Match capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (scan_hit) begin
            r_hit <= 1'b1;
        end else if (scan_miss) begin
            r_hit <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_hit) begin
            r_slot    <= r_pend_idx;
            r_m_start <= sel_start;
            r_m_other <= oth_start;
        end else if (scan_miss) begin
            r_slot <= '0;
        end
    end

    // Translation into the other address space
    always_ff @(posedge i_clk) begin
        if (r_state == sat_pkg::ST_XLATE) begin
            r_trans <= r_hit ? (r_key - r_m_start + r_m_other) : '0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == sat_pkg::ST_DONE && out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sat_pkg::ST_DONE && out_free) begin
            o_section_number <= sat_pkg::SLOT_W'(r_slot);
            o_hit            <= r_hit;
            if (file_mode) begin
                o_file_offset      <= r_key;
                o_relative_address <= r_trans;
                o_virtual_address  <= r_trans + r_base;
            end else begin
                o_file_offset      <= r_trans;
                o_relative_address <= r_key;
                o_virtual_address  <= r_virt;
            end
        end
    end

endmodule

`default_nettype wire

[src/section_address_translator_unit.sv]
// Section address translator, top level: wires the sequencer to the table.
// Depends on sat_pkg, sat_sect_mem and sat_engine.
`default_nettype none

// Holds up to MAX_SECTIONS image sections in a single-port-read table and
// translates relative, virtual or file addresses between the three forms.
// A load (command 0) produces no result and leaves the block idle; the
// block is ready again in the next cycle. A query scans entries 0 to
// min(section_count, MAX_SECTIONS)-1 in order, one table read per cycle,
// and stops at the first hit. The scan is followed by the translation
// state and then by the result register load; a previous result still
// stalled at the output holds the new one back until it transfers.
// The input stalls from the query transfer until its result is loaded; a
// finished result waits in the output register and does not block the next
// input transfer.
// Table entries hold garbage until loaded and must be loaded before any
// query scans them. Configuration: index 0 is section_count, index 1 is
// image_base (reset 0x00400000); write only while the block is idle.

module section_address_translator_unit #(
    parameter int unsigned MAX_SECTIONS = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [sat_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_cfg_wdata,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [sat_pkg::CMD_W-1:0]           i_command,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_query_address,
    input  wire  [sat_pkg::SLOT_W-1:0]          i_entry_index,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_entry_virt_start,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_entry_virt_size,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_entry_raw_start,
    input  wire  [sat_pkg::ADDR_W-1:0]          i_entry_raw_size,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [sat_pkg::ADDR_W-1:0]          o_file_offset,
    output logic [sat_pkg::ADDR_W-1:0]          o_relative_address,
    output logic [sat_pkg::ADDR_W-1:0]          o_virtual_address,
    output logic [sat_pkg::SLOT_W-1:0]          o_section_number,
    output logic                                o_hit
);

    localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_SECTIONS + 1);

    sat_pkg::t_mem_wr      mem_wr;
    logic [IDX_W-1:0]      mem_waddr;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    sat_pkg::t_sect_entry  mem_rdata;

    // Section table
    sat_sect_mem #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .IDX_W        (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_waddr (mem_waddr),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer and datapath
    sat_engine #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_query_address    (i_query_address),
        .i_entry_index      (i_entry_index),
        .i_entry_virt_start (i_entry_virt_start),
        .i_entry_virt_size  (i_entry_virt_size),
        .i_entry_raw_start  (i_entry_raw_start),
        .i_entry_raw_size   (i_entry_raw_size),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_file_offset      (o_file_offset),
        .o_relative_address (o_relative_address),
        .o_virtual_address  (o_virtual_address),
        .o_section_number   (o_section_number),
        .o_hit              (o_hit),
        .o_mem_wr           (mem_wr),
        .o_mem_waddr        (mem_waddr),
        .o_mem_re           (mem_re),
        .o_mem_raddr        (mem_raddr),
        .i_mem_rdata        (mem_rdata)
    );

endmodule

`default_nettype wire
